FILE: hdl/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types for the RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbhsv_pkg;

	// Which component holds the maximum. Ties go red, then green.
	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

endpackage

`default_nettype wire

FILE: hdl/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Pipelined RGB to HSV pixel conversion with one quotient bit per stage.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel rgb (red, green, blue, COMPONENT_BITS each, all ones = 1.0)
//   and output channel hsv (hue Q0.FRACTION_BITS, saturation
//   Q1.FRACTION_BITS, brightness = max component). Both use valid/stall; a
//   transaction completes on a clock edge with valid high and stall low.
//   Throughput: one pixel per clock while hsv_stall does not hold the output.
//   Stages: stage 1 finds max, min and sector, stage 2 forms the hue
//   numerator and divisor, then FRACTION_BITS stages each produce one bit
//   of the hue quotient and one bit of the saturation quotient with a
//   restoring subtract.
//   Stall: the whole pipeline holds while an output transaction waits on
//   hsv_stall; rgb_stall is raised in the same cycle, so nothing is lost
//   or repeated. Bubbles do not block the pipe once the output is free.
//   Reset: arst_n clears all valid bits; the pipe comes up empty.
//   Gray and black pixels give hue 0 and saturation 0.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter #(
	parameter int COMPONENT_BITS = 8,
	parameter int FRACTION_BITS  = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// input pixel
	input  wire logic                      rgb_valid,
	output logic                           rgb_stall,
	input  wire logic [COMPONENT_BITS-1:0] red,
	input  wire logic [COMPONENT_BITS-1:0] green,
	input  wire logic [COMPONENT_BITS-1:0] blue,
	// output pixel
	output logic                           hsv_valid,
	input  wire logic                      hsv_stall,
	output logic [FRACTION_BITS-1:0]       hue,
	output logic [FRACTION_BITS:0]         saturation,
	output logic [COMPONENT_BITS-1:0]      brightness
);

	import rgbhsv_pkg::*;

	localparam int CB = COMPONENT_BITS;
	localparam int FB = FRACTION_BITS;
	// hue numerator and divisor hold up to 6 * max chroma
	localparam int DW = CB + 3;
	localparam logic [FB:0] SAT_ONE = {1'b1, {FB{1'b0}}};

	// global advance: pipe moves unless the output transaction is held
	logic adv;
	assign adv       = !(hsv_valid && hsv_stall);
	assign rgb_stall = !adv;

	// ------------------------------------------------------------------
	// Stage 1: max, min, chroma and sector
	// ------------------------------------------------------------------
	logic [CB-1:0] hi_c, lo_c;
	sector_t       sect_c;

	always_comb begin
		if (red >= green && red >= blue) begin
			sect_c = SECT_RED;
			hi_c   = red;
		end else if (green >= blue) begin
			sect_c = SECT_GREEN;
			hi_c   = green;
		end else begin
			sect_c = SECT_BLUE;
			hi_c   = blue;
		end
		lo_c = red;
		if (green < lo_c) lo_c = green;
		if (blue < lo_c) lo_c = blue;
	end

	logic          valid_s1;
	logic [CB-1:0] red_s1, green_s1, blue_s1, hi_s1, chroma_s1;
	sector_t       sect_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= rgb_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_s1    <= red;
			green_s1  <= green;
			blue_s1   <= blue;
			hi_s1     <= hi_c;
			chroma_s1 <= hi_c - lo_c;
			sect_s1   <= sect_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: hue numerator, 6*C divisor, top saturation bit
	// ------------------------------------------------------------------
	logic [DW-1:0] rx, gx, bx, cx, six_c, hnum_c;

	always_comb begin
		rx    = {3'b000, red_s1};
		gx    = {3'b000, green_s1};
		bx    = {3'b000, blue_s1};
		cx    = {3'b000, chroma_s1};
		six_c = (cx << 2) + (cx << 1);
		case (sect_s1)
			SECT_RED: begin
				// negative difference wraps by one full turn
				if (green_s1 >= blue_s1) hnum_c = gx - bx;
				else                     hnum_c = six_c - (bx - gx);
			end
			SECT_GREEN: hnum_c = (cx << 1) + bx - rx;
			SECT_BLUE:  hnum_c = (cx << 2) + rx - gx;
			default:    hnum_c = '0;
		endcase
	end

	// Division pipe; index 0 is stage 2, index n is stage n + 2.
	logic          valid_sn [0:FB];
	logic          gray_sn  [0:FB];
	logic [CB-1:0] hi_sn    [0:FB];
	logic [DW-1:0] hden_sn  [0:FB];
	logic [DW-1:0] hrem_sn  [0:FB];
	logic [FB-1:0] hquo_sn  [0:FB];
	logic [CB-1:0] srem_sn  [0:FB];
	logic [FB:0]   squo_sn  [0:FB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn[0] <= 1'b0;
		end else if (adv) begin
			valid_sn[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gray_sn[0] <= (chroma_s1 == '0);
			hi_sn[0]   <= hi_s1;
			hden_sn[0] <= six_c;
			hrem_sn[0] <= hnum_c;
			hquo_sn[0] <= '0;
			// C <= max, so C >= max means C == max: quotient one, rest zero
			if (chroma_s1 >= hi_s1) begin
				srem_sn[0] <= '0;
				squo_sn[0] <= {{FB{1'b0}}, 1'b1};
			end else begin
				srem_sn[0] <= chroma_s1;
				squo_sn[0] <= '0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stages 3 .. FB+2: one restoring step per stage for both quotients
	// ------------------------------------------------------------------
	for (genvar n = 1; n <= FB; n++) begin : g_div
		logic [DW:0] htrial;
		logic [CB:0] strial;
		logic        hbit, sbit;

		always_comb begin
			htrial = {hrem_sn[n-1], 1'b0};
			strial = {srem_sn[n-1], 1'b0};
			hbit   = (htrial >= {1'b0, hden_sn[n-1]});
			sbit   = (strial >= {1'b0, hi_sn[n-1]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sn[n] <= 1'b0;
			end else if (adv) begin
				valid_sn[n] <= valid_sn[n-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				gray_sn[n] <= gray_sn[n-1];
				hi_sn[n]   <= hi_sn[n-1];
				hden_sn[n] <= hden_sn[n-1];
				hquo_sn[n] <= {hquo_sn[n-1][FB-2:0], hbit};
				squo_sn[n] <= {squo_sn[n-1][FB-1:0], sbit};
				if (hbit) hrem_sn[n] <= DW'(htrial - {1'b0, hden_sn[n-1]});
				else      hrem_sn[n] <= DW'(htrial);
				if (sbit) srem_sn[n] <= CB'(strial - {1'b0, hi_sn[n-1]});
				else      srem_sn[n] <= CB'(strial);
			end
		end
	end

	// ------------------------------------------------------------------
	// Output: gray pixels force hue and saturation to zero
	// ------------------------------------------------------------------
	assign hsv_valid  = valid_sn[FB];
	assign hue        = gray_sn[FB] ? '0 : hquo_sn[FB];
	assign saturation = gray_sn[FB] ? '0 : squo_sn[FB];
	assign brightness = hi_sn[FB];

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// black pixel carries no hue and no saturation
	a_black_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && brightness == '0 |-> hue == '0 && saturation == '0)
		else $error("black pixel with nonzero hue or saturation");

	// saturation never passes 1.0
	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> saturation <= SAT_ONE)
		else $error("saturation above 1.0");

	// final hue remainder stays below the divisor
	a_hue_rem: assert property (@(posedge clk) disable iff (!arst_n)
		valid_sn[FB] && !gray_sn[FB] |-> hrem_sn[FB] < hden_sn[FB])
		else $error("hue remainder not below divisor");

	// final saturation remainder stays below the divisor
	a_sat_rem: assert property (@(posedge clk) disable iff (!arst_n)
		valid_sn[FB] && !gray_sn[FB] |-> srem_sn[FB] < hi_sn[FB])
		else $error("saturation remainder not below divisor");

endmodule

`default_nettype wire
